// File: rtl/phsd_pkg.sv
package phsd_pkg;

	localparam int MAX_LEVELS_DEF   = 24;
	localparam int SYMBOL_SLOTS_DEF = 256;

	localparam int BYTE_W     = 8;
	localparam int NODE_W     = 9;   // leaf or internal-node count per level
	localparam int CARRY_W    = 10;  // running child total during count conversion
	localparam int CODE_W     = 24;
	localparam int LEN_W      = 32;
	localparam int HEAD_BYTES = 6;   // two magic bytes and the 32-bit length
	localparam int MAGIC_BYTES = 2;
	localparam int END_LEAVES = 2;   // extra leaves on the deepest level

	typedef enum logic [1:0] {
		KIND_SYM      = 2'd0,
		KIND_MATCH    = 2'd1,
		KIND_MISMATCH = 2'd2,
		KIND_BAD      = 2'd3
	} kind_t;

endpackage

// File: rtl/phsd_if.sv
interface phsd_in_if;
	logic                          valid;
	logic                          ready;
	logic [phsd_pkg::BYTE_W-1:0]   byte_value;
	logic                          new_stream;

	modport source (output valid, output byte_value, output new_stream, input ready);
	modport sink (input valid, input byte_value, input new_stream, output ready);
endinterface

interface phsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [phsd_pkg::BYTE_W-1:0]   symbol;
	logic                          last;

	modport source (output valid, output kind, output symbol, output last, input ready);
	modport sink (input valid, input kind, input symbol, input last, output ready);
endinterface

// File: rtl/packed_huffman_stream_decoder_core.sv
// Header byte: from transfer to ready again it is accepted, processed, and a result flushed.
// End-slot byte: each level table entry, from the deepest level up, is read, then
//   rewritten, over the one read port of the level memory.
// Data byte: each bit decoded takes a level table read and an evaluation, plus a symbol
//   memory read per decoded symbol; fewer bits when the stream ends within the byte; one byte
//   in flight at a time. A held result stalls the sequencer until it can move on.
// Reset clears all control state; the level table and symbol memories are not cleared.
module packed_huffman_stream_decoder_core #(
	parameter int MAX_LEVELS   = phsd_pkg::MAX_LEVELS_DEF,
	parameter int SYMBOL_SLOTS = phsd_pkg::SYMBOL_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	phsd_in_if.sink     in_ch,
	phsd_out_if.source  out_ch
);
	import phsd_pkg::*;

	localparam int LV_W  = $clog2(MAX_LEVELS + 2);
	localparam int LA_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int EM_W  = $clog2(SYMBOL_SLOTS + 1);
	localparam int SA_W  = $clog2(SYMBOL_SLOTS);
	localparam int HP_W  = (EM_W > LV_W) ? EM_W : LV_W;
	localparam int SUM_W = ((EM_W > BYTE_W) ? EM_W : BYTE_W) + 1;
	localparam int P_W   = ((CODE_W > EM_W) ? CODE_W : EM_W) + 1;
	localparam int LT_W  = EM_W + NODE_W;

	// parse phase of the current stream
	typedef enum logic [6:0] {
		PH_HEAD    = 7'b0000001,
		PH_LEVELS  = 7'b0000010,
		PH_COUNTS  = 7'b0000100,
		PH_SYMS    = 7'b0001000,
		PH_ENDSLOT = 7'b0010000,
		PH_DATA    = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	// per-byte sequencer
	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_BYTE   = 8'b00000010,
		S_LVL_RD = 8'b00000100,
		S_LVL_EV = 8'b00001000,
		S_SYM    = 8'b00010000,
		S_CV_RD  = 8'b00100000,
		S_CV_WR  = 8'b01000000,
		S_FIN    = 8'b10000000
	} seq_t;

	seq_t                 seq_q;
	phase_t               phase_q;
	logic [HP_W-1:0]      hpos_q;
	logic [LEN_W-1:0]     rem_len_q;
	logic [LV_W-1:0]      lvl_total_q;
	logic [EM_W-1:0]      em_q;        // end marker index
	logic [CODE_W-1:0]    cv_q;
	logic [LV_W-1:0]      code_lvl_q;
	logic [CARRY_W-1:0]   carry_q;
	logic [LA_W-1:0]      cv_idx_q;    // level under conversion
	logic [BYTE_W-1:0]    byte_q;
	logic [2:0]           bit_idx_q;

	// one result is held back until we know whether it is the last of its byte
	logic                 pend_valid_q;
	kind_t                pend_kind_q;
	logic [BYTE_W-1:0]    pend_sym_q;

	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [BYTE_W-1:0]    out_sym_q;
	logic                 out_last_q;

	// level table: {start offset, node count} per level, one sync-read port
	logic [LT_W-1:0]      lvl_mem [MAX_LEVELS];
	logic [LT_W-1:0]      lt_rd_q;
	logic                 lt_we;
	logic [LA_W-1:0]      lt_wa;
	logic [LT_W-1:0]      lt_wd;
	logic [LA_W-1:0]      lt_ra;

	// symbol store
	logic [BYTE_W-1:0]    sym_mem [SYMBOL_SLOTS];
	logic [BYTE_W-1:0]    sym_rd_q;
	logic                 sym_we;
	logic [SA_W-1:0]      sym_wa;
	logic [SA_W-1:0]      sym_ra;

	logic                 emit_req;
	kind_t                emit_kind;
	logic [BYTE_W-1:0]    emit_sym;
	logic                 can_push;
	logic                 stall;
	logic                 fin_push;
	logic                 out_load;

	logic [NODE_W-1:0]    rd_node;
	logic [EM_W-1:0]      rd_start;
	logic [P_W-1:0]       leaf_pos;
	logic                 code_inner;
	logic                 lvl_range_bad;
	logic                 lvl_bad;
	logic                 counts_bad;
	logic [SUM_W-1:0]     em_plus_b;
	logic                 bit_in;
	logic [LV_W-1:0]      code_lvl_nx;
	logic [CARRY_W-1:0]   conv_add;
	logic [CARRY_W-1:0]   carry_half;
	logic [LA_W-1:0]      lvl_idx;

	assign rd_node    = lt_rd_q[NODE_W-1:0];
	assign rd_start   = lt_rd_q[LT_W-1:NODE_W];
	assign code_inner = cv_q < CODE_W'(rd_node);
	assign leaf_pos   = P_W'(rd_start) + P_W'(cv_q) - P_W'(rd_node);
	assign em_plus_b  = SUM_W'(em_q) + SUM_W'(byte_q);
	assign bit_in     = byte_q[3'd7 - bit_idx_q];
	assign code_lvl_nx = code_lvl_q + LV_W'(1);
	assign lvl_idx    = LA_W'(code_lvl_q - LV_W'(1));
	assign lvl_range_bad = (code_lvl_q == '0) || (code_lvl_q > lvl_total_q) ||
		(code_lvl_q > LV_W'(MAX_LEVELS));
	assign lvl_bad    = (byte_q == '0) || (SUM_W'(byte_q) > SUM_W'(MAX_LEVELS));
	assign counts_bad = (hpos_q >= HP_W'(lvl_total_q)) || (hpos_q >= HP_W'(MAX_LEVELS)) ||
		(em_plus_b + SUM_W'(1) > SUM_W'(SYMBOL_SLOTS));
	// deepest level carries the two extra leaves
	assign conv_add   = CARRY_W'(rd_node) + ((cv_idx_q == LA_W'(lvl_total_q - LV_W'(1))) ?
		CARRY_W'(END_LEAVES) : '0);
	assign carry_half = carry_q >> 1;

	always_comb begin
		emit_req  = 1'b0;
		emit_kind = KIND_SYM;
		emit_sym  = '0;
		lt_we     = 1'b0;
		lt_wa     = '0;
		lt_wd     = '0;
		lt_ra     = '0;
		sym_we    = 1'b0;
		sym_wa    = '0;
		sym_ra    = '0;
		unique case (seq_q)
			S_BYTE: begin
				unique case (phase_q)
					PH_LEVELS: begin
						if (lvl_bad) begin
							emit_req  = 1'b1;
							emit_kind = KIND_BAD;
						end
					end
					PH_COUNTS: begin
						if (counts_bad) begin
							emit_req  = 1'b1;
							emit_kind = KIND_BAD;
						end else begin
							lt_we = 1'b1;
							lt_wa = hpos_q[LA_W-1:0];
							lt_wd = {em_q, NODE_W'(byte_q)};
						end
					end
					PH_SYMS: begin
						if (hpos_q < HP_W'(SYMBOL_SLOTS)) begin
							sym_we = 1'b1;
							sym_wa = hpos_q[SA_W-1:0];
						end
					end
					PH_ENDSLOT: begin
						if (em_q < EM_W'(SYMBOL_SLOTS)) begin
							sym_we = 1'b1;
							sym_wa = em_q[SA_W-1:0];
						end
					end
					default: ;
				endcase
			end
			S_LVL_RD: begin
				lt_ra = lvl_idx;
				if (lvl_range_bad) begin
					emit_req  = 1'b1;
					emit_kind = KIND_BAD;
				end
			end
			S_LVL_EV: begin
				if (code_inner) begin
					if (code_lvl_nx > lvl_total_q) begin
						emit_req  = 1'b1;
						emit_kind = KIND_BAD;
					end
				end else if (leaf_pos == P_W'(em_q)) begin
					emit_req  = 1'b1;
					emit_kind = (rem_len_q == '0) ? KIND_MATCH : KIND_MISMATCH;
				end else if (leaf_pos > P_W'(em_q) || leaf_pos >= P_W'(SYMBOL_SLOTS)) begin
					emit_req  = 1'b1;
					emit_kind = KIND_BAD;
				end else begin
					sym_ra = leaf_pos[SA_W-1:0];
				end
			end
			S_SYM: begin
				emit_req  = 1'b1;
				emit_kind = KIND_SYM;
				emit_sym  = sym_rd_q;
			end
			S_CV_RD: begin
				lt_ra = cv_idx_q;
			end
			S_CV_WR: begin
				lt_we = 1'b1;
				lt_wa = cv_idx_q;
				lt_wd = {rd_start, carry_half[NODE_W-1:0]};
			end
			default: ;
		endcase
	end

	assign can_push = !out_valid_q || out_ch.ready;
	assign stall    = emit_req && pend_valid_q && !can_push;
	assign fin_push = (seq_q == S_FIN) && pend_valid_q;
	assign out_load = (emit_req && pend_valid_q && can_push) || (fin_push && can_push);

	// memories: entries of one stream are written before they are read, and the
	// conversion reads and rewrites one entry before moving on, so no forwarding.
	// Read data is only loaded in the read states, so it holds through a stall.
	always_ff @(posedge clk) begin
		if (lt_we) begin
			lvl_mem[lt_wa] <= lt_wd;
		end
		if ((seq_q == S_LVL_RD) || (seq_q == S_CV_RD)) begin
			lt_rd_q <= lvl_mem[lt_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_wa] <= byte_q;
		end
		if (seq_q == S_LVL_EV) begin
			sym_rd_q <= sym_mem[sym_ra];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= pend_kind_q;
			out_sym_q  <= pend_sym_q;
			out_last_q <= fin_push;
		end
	end

	// held-back result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (emit_req && !stall) begin
			pend_valid_q <= 1'b1;
		end else if (fin_push && can_push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && !stall) begin
			pend_kind_q <= emit_kind;
			pend_sym_q  <= emit_sym;
		end
	end

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			phase_q     <= PH_HEAD;
			hpos_q      <= '0;
			rem_len_q   <= '0;
			lvl_total_q <= '0;
			em_q        <= '0;
			cv_q        <= '0;
			code_lvl_q  <= LV_W'(1);
			carry_q     <= '0;
			cv_idx_q    <= '0;
			byte_q      <= '0;
			bit_idx_q   <= '0;
		end else if (!stall) begin
			unique case (seq_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						byte_q <= in_ch.byte_value;
						if (in_ch.new_stream) begin
							phase_q     <= PH_HEAD;
							hpos_q      <= '0;
							rem_len_q   <= '0;
							lvl_total_q <= '0;
							em_q        <= '0;
							cv_q        <= '0;
							code_lvl_q  <= LV_W'(1);
							carry_q     <= '0;
						end
						seq_q <= S_BYTE;
					end
				end
				S_BYTE: begin
					seq_q <= S_FIN;
					unique case (phase_q)
						PH_HEAD: begin
							if (hpos_q >= HP_W'(MAGIC_BYTES)) begin
								rem_len_q <= {rem_len_q[LEN_W-BYTE_W-1:0], byte_q};
							end
							if (hpos_q + HP_W'(1) >= HP_W'(HEAD_BYTES)) begin
								hpos_q  <= '0;
								phase_q <= PH_LEVELS;
							end else begin
								hpos_q <= hpos_q + HP_W'(1);
							end
						end
						PH_LEVELS: begin
							if (lvl_bad) begin
								phase_q <= PH_DONE;
							end else begin
								lvl_total_q <= LV_W'(byte_q);
								hpos_q      <= '0;
								em_q        <= '0;
								phase_q     <= PH_COUNTS;
							end
						end
						PH_COUNTS: begin
							if (counts_bad) begin
								phase_q <= PH_DONE;
							end else begin
								em_q <= EM_W'(em_plus_b);
								if (hpos_q + HP_W'(1) == HP_W'(lvl_total_q)) begin
									hpos_q  <= '0;
									phase_q <= (em_plus_b != '0) ? PH_SYMS : PH_ENDSLOT;
								end else begin
									hpos_q <= hpos_q + HP_W'(1);
								end
							end
						end
						PH_SYMS: begin
							if (hpos_q + HP_W'(1) >= HP_W'(em_q)) begin
								hpos_q  <= '0;
								phase_q <= PH_ENDSLOT;
							end else begin
								hpos_q <= hpos_q + HP_W'(1);
							end
						end
						PH_ENDSLOT: begin
							em_q       <= em_q + EM_W'(1);
							cv_q       <= '0;
							code_lvl_q <= LV_W'(1);
							carry_q    <= '0;
							cv_idx_q   <= LA_W'(lvl_total_q - LV_W'(1));
							phase_q    <= PH_DATA;
							seq_q      <= S_CV_RD;
						end
						PH_DATA: begin
							bit_idx_q <= '0;
							seq_q     <= S_LVL_RD;
						end
						default: ;
					endcase
				end
				S_LVL_RD: begin
					cv_q <= {cv_q[CODE_W-2:0], bit_in};
					if (lvl_range_bad) begin
						phase_q <= PH_DONE;
						seq_q   <= S_FIN;
					end else begin
						seq_q <= S_LVL_EV;
					end
				end
				S_LVL_EV: begin
					if (code_inner) begin
						code_lvl_q <= code_lvl_nx;
						if (code_lvl_nx > lvl_total_q) begin
							phase_q <= PH_DONE;
							seq_q   <= S_FIN;
						end else if (bit_idx_q == 3'd7) begin
							seq_q <= S_FIN;
						end else begin
							bit_idx_q <= bit_idx_q + 3'd1;
							seq_q     <= S_LVL_RD;
						end
					end else if (leaf_pos == P_W'(em_q) || leaf_pos > P_W'(em_q) ||
						leaf_pos >= P_W'(SYMBOL_SLOTS)) begin
						// end marker or code past the table: stream stops
						phase_q <= PH_DONE;
						seq_q   <= S_FIN;
					end else begin
						seq_q <= S_SYM;
					end
				end
				S_SYM: begin
					rem_len_q  <= rem_len_q - LEN_W'(1);
					code_lvl_q <= LV_W'(1);
					cv_q       <= '0;
					if (bit_idx_q == 3'd7) begin
						seq_q <= S_FIN;
					end else begin
						bit_idx_q <= bit_idx_q + 3'd1;
						seq_q     <= S_LVL_RD;
					end
				end
				S_CV_RD: begin
					seq_q <= S_CV_WR;
				end
				S_CV_WR: begin
					carry_q <= carry_half + conv_add;
					if (cv_idx_q == '0) begin
						seq_q <= S_FIN;
					end else begin
						cv_idx_q <= cv_idx_q - LA_W'(1);
						seq_q    <= S_CV_RD;
					end
				end
				S_FIN: begin
					if (!(fin_push && !can_push)) begin
						seq_q <= S_IDLE;
					end
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready   = (seq_q == S_IDLE);
	assign out_ch.valid  = out_valid_q;
	assign out_ch.kind   = out_kind_q;
	assign out_ch.symbol = out_sym_q;
	assign out_ch.last   = out_last_q;

endmodule

// File: rtl/phsd_checker.sv
module phsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_symbol,
	input logic       out_last
);
	import phsd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_symbol))
		else $error("result changed while stalled");

	a_end_zero_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_SYM) |-> out_symbol == '0)
		else $error("non-symbol result with nonzero symbol");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind != KIND_SYM) |-> out_last)
		else $error("stream end not last of its byte");

	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second byte taken while one is in work");

endmodule

bind packed_huffman_stream_decoder_core phsd_checker u_phsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.kind),
	.out_symbol (out_ch.symbol),
	.out_last   (out_ch.last)
);
